### rtl/ffra_pkg.sv
// Shared types, codes and helpers of the first-fit range allocator.
// Depends on nothing; every other file of the block uses it.
`default_nettype none
package ffra_pkg;

  localparam int START_W = 19;
  localparam int LEN_W   = 20;
  localparam int CMD_W   = 5;

  localparam logic [LEN_W-1:0] PAGE_CAP    = 20'd524288;
  localparam logic [LEN_W-1:0] PAGES_RESET = 20'd32768;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_LIST_FULL = 3'd2;
  localparam logic [2:0] ST_DISABLED = 3'd3;
  localparam logic [2:0] ST_ZERO_LEN = 3'd4;

  // Item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_PAGES  = 1'b1;

  // Datapath micro-operations
  localparam logic [CMD_W-1:0] OP_NOP        = 5'd0;
  localparam logic [CMD_W-1:0] OP_LOAD       = 5'd1;
  localparam logic [CMD_W-1:0] OP_RD_IDX     = 5'd2;
  localparam logic [CMD_W-1:0] OP_A_SHRINK   = 5'd3;
  localparam logic [CMD_W-1:0] OP_A_EXACT    = 5'd4;
  localparam logic [CMD_W-1:0] OP_IDX_INC    = 5'd5;
  localparam logic [CMD_W-1:0] OP_F_PREV     = 5'd6;
  localparam logic [CMD_W-1:0] OP_F_CUR      = 5'd7;
  localparam logic [CMD_W-1:0] OP_J_BOTH     = 5'd8;
  localparam logic [CMD_W-1:0] OP_J_PREV     = 5'd9;
  localparam logic [CMD_W-1:0] OP_J_NEXT     = 5'd10;
  localparam logic [CMD_W-1:0] OP_INS_START  = 5'd11;
  localparam logic [CMD_W-1:0] OP_RD_IDX1    = 5'd12;
  localparam logic [CMD_W-1:0] OP_E_WR       = 5'd13;
  localparam logic [CMD_W-1:0] OP_E_DONE     = 5'd14;
  localparam logic [CMD_W-1:0] OP_RD_JDXM1   = 5'd15;
  localparam logic [CMD_W-1:0] OP_I_WR       = 5'd16;
  localparam logic [CMD_W-1:0] OP_I_DONE     = 5'd17;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } range_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic init_busy;
    logic enable;
    logic kind;
    logic zero;
    logic idx_at_count;
    logic hit;
    logic exact;
    logic below;
    logic join_prev;
    logic join_next;
    logic full;
    logic e_last;
    logic i_last;
  } dp_stat_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W+1:0] v);
    logic [LEN_W-1:0] r;
    if (v[LEN_W+1:LEN_W] != 2'b00) begin
      r = '1;
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ffra_regs.sv
// APB-style configuration registers of the range allocator.
// Depends on ffra_pkg for register indexes and reset values.
`default_nettype none
module ffra_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             arena_enable,
  output logic [ffra_pkg::LEN_W-1:0] arena_pages,
  output logic             cfg_wr
);

  logic                        enable_r, enable_nxt;
  logic [ffra_pkg::LEN_W-1:0]  pages_r, pages_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    enable_nxt = enable_r;
    pages_nxt  = pages_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        ffra_pkg::REG_ENABLE: enable_nxt = pwdata[0];
        ffra_pkg::REG_PAGES:  pages_nxt  = pwdata[ffra_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      pages_r  <= ffra_pkg::PAGES_RESET;
    end else begin
      enable_r <= enable_nxt;
      pages_r  <= pages_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      ffra_pkg::REG_ENABLE: prdata = {31'd0, enable_r};
      ffra_pkg::REG_PAGES:  prdata = {12'd0, pages_r};
      default:              prdata = '0;
    endcase
  end

  assign arena_enable = enable_r;
  assign arena_pages  = pages_r;

endmodule
`default_nettype wire

### rtl/ffra_dp.sv
// Datapath of the range allocator: free-list memory, scan indexes, item and
// merge registers. Depends on ffra_pkg; driven by ffra_ctrl commands.
`default_nettype none
module ffra_dp #(
  parameter int FREE_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr,
  input  wire logic        arena_enable,
  input  wire logic [ffra_pkg::LEN_W-1:0]   arena_pages,
  input  wire logic        in_kind,
  input  wire logic [ffra_pkg::LEN_W-1:0]   in_page_count,
  input  wire logic [ffra_pkg::START_W-1:0] in_start_page,
  input  wire ffra_pkg::dp_cmd_t cmd,
  output ffra_pkg::dp_stat_t     stat,
  output logic [ffra_pkg::START_W-1:0]      out_granted_page
);

  localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);

  ffra_pkg::range_t mem [FREE_SLOTS];
  ffra_pkg::range_t rd_q;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] jdx_r, jdx_nxt;
  ffra_pkg::range_t prev_r, prev_nxt;
  ffra_pkg::range_t cur_r, cur_nxt;
  logic prev_valid_r, prev_valid_nxt;
  logic has_next_r, has_next_nxt;
  logic init_pend_r, init_pend_nxt;
  logic kind_r, kind_nxt;
  logic [ffra_pkg::LEN_W-1:0]   need_r, need_nxt;
  logic [ffra_pkg::START_W-1:0] s_r, s_nxt;
  logic [ffra_pkg::START_W-1:0] granted_r, granted_nxt;
  logic [ffra_pkg::START_W-1:0] out_granted_r, out_granted_nxt;

  logic             rd_en, we;
  logic [AW-1:0]    rd_addr, wr_addr;
  ffra_pkg::range_t wr_data;

  logic [CW-1:0] idx_m1, idx_p1, jdx_m1;
  logic [ffra_pkg::LEN_W-1:0] pages_cap;
  logic [ffra_pkg::START_W-1:0] shrink_start;
  logic [ffra_pkg::LEN_W+1:0] merge_prev, merge_next, merge_both;
  logic [ffra_pkg::LEN_W:0]   prev_end, free_end;

  assign idx_m1 = idx_r - 1'b1;
  assign idx_p1 = idx_r + 1'b1;
  assign jdx_m1 = jdx_r - 1'b1;
  assign pages_cap = (arena_pages > ffra_pkg::PAGE_CAP) ? ffra_pkg::PAGE_CAP : arena_pages;
  assign shrink_start = rd_q.start + need_r[ffra_pkg::START_W-1:0];
  assign prev_end = {2'b00, prev_r.start} + {1'b0, prev_r.len};
  assign free_end = {2'b00, s_r} + {1'b0, need_r};
  assign merge_prev = {2'b00, prev_r.len} + {2'b00, need_r};
  assign merge_next = {2'b00, cur_r.len} + {2'b00, need_r};
  assign merge_both = merge_prev + {2'b00, cur_r.len};

  always_comb begin
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    jdx_nxt         = jdx_r;
    prev_nxt        = prev_r;
    cur_nxt         = cur_r;
    prev_valid_nxt  = prev_valid_r;
    has_next_nxt    = has_next_r;
    init_pend_nxt   = init_pend_r;
    kind_nxt        = kind_r;
    need_nxt        = need_r;
    s_nxt           = s_r;
    granted_nxt     = granted_r;
    out_granted_nxt = out_granted_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r[AW-1:0];
    we              = 1'b0;
    wr_addr         = idx_r[AW-1:0];
    wr_data         = rd_q;

    unique case (cmd.op)
      ffra_pkg::OP_NOP: ;
      ffra_pkg::OP_LOAD: begin
        kind_nxt       = in_kind;
        need_nxt       = in_page_count;
        s_nxt          = in_start_page;
        idx_nxt        = '0;
        prev_valid_nxt = 1'b0;
        has_next_nxt   = 1'b0;
        granted_nxt    = '0;
      end
      ffra_pkg::OP_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[AW-1:0];
      end
      ffra_pkg::OP_A_SHRINK: begin
        granted_nxt   = rd_q.start;
        we            = 1'b1;
        wr_addr       = idx_r[AW-1:0];
        wr_data.start = shrink_start;
        wr_data.len   = rd_q.len - need_r;
      end
      ffra_pkg::OP_A_EXACT:  granted_nxt = rd_q.start;
      ffra_pkg::OP_IDX_INC:  idx_nxt = idx_p1;
      ffra_pkg::OP_F_PREV: begin
        prev_nxt       = rd_q;
        prev_valid_nxt = 1'b1;
        idx_nxt        = idx_p1;
      end
      ffra_pkg::OP_F_CUR: begin
        cur_nxt      = rd_q;
        has_next_nxt = 1'b1;
      end
      ffra_pkg::OP_J_BOTH: begin
        we            = 1'b1;
        wr_addr       = idx_m1[AW-1:0];
        wr_data.start = prev_r.start;
        wr_data.len   = ffra_pkg::sat_len(merge_both);
      end
      ffra_pkg::OP_J_PREV: begin
        we            = 1'b1;
        wr_addr       = idx_m1[AW-1:0];
        wr_data.start = prev_r.start;
        wr_data.len   = ffra_pkg::sat_len(merge_prev);
      end
      ffra_pkg::OP_J_NEXT: begin
        we            = 1'b1;
        wr_addr       = idx_r[AW-1:0];
        wr_data.start = s_r;
        wr_data.len   = ffra_pkg::sat_len(merge_next);
      end
      ffra_pkg::OP_INS_START: jdx_nxt = count_r;
      ffra_pkg::OP_RD_IDX1: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[AW-1:0];
      end
      ffra_pkg::OP_E_WR: begin
        we      = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_q;
        idx_nxt = idx_p1;
      end
      ffra_pkg::OP_E_DONE: count_nxt = count_r - 1'b1;
      ffra_pkg::OP_RD_JDXM1: begin
        rd_en   = 1'b1;
        rd_addr = jdx_m1[AW-1:0];
      end
      ffra_pkg::OP_I_WR: begin
        we      = 1'b1;
        wr_addr = jdx_r[AW-1:0];
        wr_data = rd_q;
        jdx_nxt = jdx_m1;
      end
      ffra_pkg::OP_I_DONE: begin
        we            = 1'b1;
        wr_addr       = idx_r[AW-1:0];
        wr_data.start = s_r;
        wr_data.len   = need_r;
        count_nxt     = count_r + 1'b1;
      end
      default: ;
    endcase

    if (cmd.out_load) begin
      out_granted_nxt = granted_r;
    end

    // Rebuild the list as one arena-wide range (capped), or as an empty list when disabled or zero-sized
    if (init_pend_r) begin
      we            = 1'b1;
      wr_addr       = '0;
      wr_data.start = '0;
      wr_data.len   = pages_cap;
      count_nxt     = (arena_enable && pages_cap != '0) ? CW'(1) : '0;
      init_pend_nxt = 1'b0;
    end
    if (cfg_wr) begin
      init_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(1);
      init_pend_r <= 1'b1;
    end else begin
      count_r     <= count_nxt;
      init_pend_r <= init_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    jdx_r         <= jdx_nxt;
    prev_r        <= prev_nxt;
    cur_r         <= cur_nxt;
    prev_valid_r  <= prev_valid_nxt;
    has_next_r    <= has_next_nxt;
    kind_r        <= kind_nxt;
    need_r        <= need_nxt;
    s_r           <= s_nxt;
    granted_r     <= granted_nxt;
    out_granted_r <= out_granted_nxt;
  end

  always_comb begin
    stat.init_busy    = init_pend_r;
    stat.enable       = arena_enable;
    stat.kind         = kind_r;
    stat.zero         = (need_r == '0);
    stat.idx_at_count = (idx_r == count_r);
    stat.hit          = (rd_q.len >= need_r);
    stat.exact        = (rd_q.len == need_r);
    stat.below        = (rd_q.start < s_r);
    stat.join_prev    = prev_valid_r && (prev_end == {2'b00, s_r});
    stat.join_next    = has_next_r && (free_end == {2'b00, cur_r.start});
    stat.full         = (count_r >= SLOTS_C);
    stat.e_last       = ({1'b0, idx_r} + 1'b1) >= {1'b0, count_r};
    stat.i_last       = (jdx_r == idx_r);
  end

  assign out_granted_page = out_granted_r;

endmodule
`default_nettype wire

### rtl/ffra_ctrl.sv
// Sequencer of the range allocator: scan, merge, erase and insert steps,
// plus the result register handshake. Depends on ffra_pkg.
`default_nettype none
module ffra_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_ready,
  output logic      out_valid,
  output logic [2:0] out_status,
  input  wire ffra_pkg::dp_stat_t stat,
  output ffra_pkg::dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_CMP = 4'd3;
  localparam logic [3:0] S_F_RD  = 4'd4;
  localparam logic [3:0] S_F_CMP = 4'd5;
  localparam logic [3:0] S_F_DEC = 4'd6;
  localparam logic [3:0] S_E_RD  = 4'd7;
  localparam logic [3:0] S_E_WR  = 4'd8;
  localparam logic [3:0] S_I_RD  = 4'd9;
  localparam logic [3:0] S_I_WR  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] wst_r, wst_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE) && !stat.init_busy;

  always_comb begin
    state_nxt      = state_r;
    wst_nxt        = wst_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;
    cmd.op         = ffra_pkg::OP_NOP;
    cmd.out_load   = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op    = ffra_pkg::OP_LOAD;
          wst_nxt   = ffra_pkg::ST_OK;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!stat.enable) begin
          wst_nxt   = ffra_pkg::ST_DISABLED;
          state_nxt = S_DONE;
        end else if (stat.kind == ffra_pkg::KIND_ALLOC) begin
          state_nxt = S_A_RD;
        end else if (stat.zero) begin
          wst_nxt   = ffra_pkg::ST_ZERO_LEN;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_A_RD: begin
        if (stat.idx_at_count) begin
          wst_nxt   = ffra_pkg::ST_NO_FIT;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffra_pkg::OP_RD_IDX;
          state_nxt = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (!stat.hit) begin
          cmd.op    = ffra_pkg::OP_IDX_INC;
          state_nxt = S_A_RD;
        end else if (stat.exact) begin
          cmd.op    = ffra_pkg::OP_A_EXACT;
          state_nxt = S_E_RD;
        end else begin
          cmd.op    = ffra_pkg::OP_A_SHRINK;
          state_nxt = S_DONE;
        end
      end
      S_F_RD: begin
        if (stat.idx_at_count) begin
          state_nxt = S_F_DEC;
        end else begin
          cmd.op    = ffra_pkg::OP_RD_IDX;
          state_nxt = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (stat.below) begin
          cmd.op    = ffra_pkg::OP_F_PREV;
          state_nxt = S_F_RD;
        end else begin
          cmd.op    = ffra_pkg::OP_F_CUR;
          state_nxt = S_F_DEC;
        end
      end
      S_F_DEC: begin
        if (stat.join_prev && stat.join_next) begin
          cmd.op    = ffra_pkg::OP_J_BOTH;
          state_nxt = S_E_RD;
        end else if (stat.join_prev) begin
          cmd.op    = ffra_pkg::OP_J_PREV;
          state_nxt = S_DONE;
        end else if (stat.join_next) begin
          cmd.op    = ffra_pkg::OP_J_NEXT;
          state_nxt = S_DONE;
        end else if (stat.full) begin
          wst_nxt   = ffra_pkg::ST_LIST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffra_pkg::OP_INS_START;
          state_nxt = S_I_RD;
        end
      end
      S_E_RD: begin
        if (stat.e_last) begin
          cmd.op    = ffra_pkg::OP_E_DONE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffra_pkg::OP_RD_IDX1;
          state_nxt = S_E_WR;
        end
      end
      S_E_WR: begin
        cmd.op    = ffra_pkg::OP_E_WR;
        state_nxt = S_E_RD;
      end
      S_I_RD: begin
        if (stat.i_last) begin
          cmd.op    = ffra_pkg::OP_I_DONE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffra_pkg::OP_RD_JDXM1;
          state_nxt = S_I_WR;
        end
      end
      S_I_WR: begin
        cmd.op    = ffra_pkg::OP_I_WR;
        state_nxt = S_I_RD;
      end
      S_DONE: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          out_status_nxt = wst_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wst_r        <= wst_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

### rtl/first_fit_range_allocator.sv
// First-fit page-range allocator with a coalescing, address-ordered free
// list of FREE_SLOTS ranges kept in a single-port-write, registered-read
// memory. An alloc transaction (kind 0) scans from the lowest range for the
// first one at least page_count long, shrinks it from the front or removes
// it on an exact fit, and returns its old start; a free transaction (kind 1)
// finds its place in address order, merges with the touching neighbours and
// otherwise opens a new slot (status list_full when none is left). One item
// is worked on at a time; its cost grows with each range scanned and each
// range moved by an erase or insert, and the memory's one read port and its
// read register set the cost per range. A result waits in an output
// register, and the next transaction is accepted while it waits. After reset
// and after every configuration write the list is rebuilt, and in_ready
// stays low while the rebuild is pending.
// Depends on ffra_pkg, ffra_regs, ffra_dp and ffra_ctrl.
`default_nettype none
module first_fit_range_allocator #(
  parameter int FREE_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [19:0] in_page_count,
  input  wire logic [18:0] in_start_page,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [18:0]      out_granted_page,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                       arena_enable;
  logic [ffra_pkg::LEN_W-1:0] arena_pages;
  logic                       cfg_wr;
  ffra_pkg::dp_cmd_t          cmd;
  ffra_pkg::dp_stat_t         stat;

  // Register file: a write also requests a list rebuild
  ffra_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .arena_enable (arena_enable),
    .arena_pages  (arena_pages),
    .cfg_wr       (cfg_wr)
  );

  // Sequencer: steps the datapath and owns the result handshake
  ffra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_status (out_status),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: free-list memory, indexes and merge arithmetic
  ffra_dp #(
    .FREE_SLOTS (FREE_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr           (cfg_wr),
    .arena_enable     (arena_enable),
    .arena_pages      (arena_pages),
    .in_kind          (in_kind),
    .in_page_count    (in_page_count),
    .in_start_page    (in_start_page),
    .cmd              (cmd),
    .stat             (stat),
    .out_granted_page (out_granted_page)
  );

endmodule
`default_nettype wire

### verif/tb_first_fit_range_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench of first_fit_range_allocator: alloc and free transactions are
// checked against an in-bench first-fit free-list predictor. Depends on ffra_pkg and the RTL.
module tb_first_fit_range_allocator;

  localparam int FREE_SLOTS  = 64;
  localparam int STALL_LIMIT = 8000;               // quiet cycles before giving up
  localparam int TAIL_CYCLES = 4 * FREE_SLOTS + 8; // worst item latency plus margin
  localparam logic [2:0] ENABLE_ADDR = {ffra_pkg::REG_ENABLE, 2'b00};
  localparam logic [2:0] PAGES_ADDR  = {ffra_pkg::REG_PAGES, 2'b00};

  // One expected result, with the transaction that caused it for messages
  typedef struct {
    logic [2:0]  status;
    logic [18:0] granted;
    logic        kind;
    logic [19:0] count;
    logic [18:0] start;
  } reply_t;

  // A range handed out by the block and not yet given back
  typedef struct {
    logic [18:0] start;
    logic [19:0] len;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = ffra_pkg::KIND_ALLOC;
  logic [19:0] in_page_count = '0;
  logic [18:0] in_start_page = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [18:0] out_granted_page;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the free list and the registers
  logic [18:0] free_start [FREE_SLOTS];
  logic [19:0] free_len [FREE_SLOTS];
  int          free_cnt;
  logic        cfg_enable = 1'b1;
  logic [19:0] cfg_pages = ffra_pkg::PAGES_RESET;

  reply_t pending_replies[$];
  grant_t live_grants[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  replies_checked = 0;
  int  cfg_writes = 0;
  int  status_seen [5];
  bit  idle_mix = 1'b1;      // 0 gives a stretch with no gaps on either side
  int  sink_hold_cycles = 0; // set to ask the receiver for one long hold-off

  first_fit_range_allocator #(.FREE_SLOTS(FREE_SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_page_count(in_page_count), .in_start_page(in_start_page),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_granted_page(out_granted_page),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Reinitialise to one range covering the arena (capped), or to nothing
  function automatic void rebuild_free_list();
    logic [19:0] pages;
    pages = (cfg_pages > ffra_pkg::PAGE_CAP) ? ffra_pkg::PAGE_CAP : cfg_pages;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      free_start[i] = '0;
      free_len[i] = '0;
    end
    free_cnt = 0;
    if (cfg_enable && pages != 0) begin
      free_len[0] = pages;
      free_cnt = 1;
    end
  endfunction

  function automatic void drop_slot(input int idx);
    for (int j = idx; j < free_cnt - 1; j++) begin
      free_start[j] = free_start[j+1];
      free_len[j] = free_len[j+1];
    end
    free_cnt--;
  endfunction

  function automatic logic [19:0] clamp_len(input longint unsigned v);
    return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
  endfunction

  // First fit: erase on an exact fit, else shrink from the front (start wraps)
  function automatic logic [2:0] carve_first_fit(input logic [19:0] need,
                                                 output logic [18:0] granted);
    granted = '0;
    for (int i = 0; i < free_cnt; i++) begin
      if (free_len[i] >= need) begin
        granted = free_start[i];
        if (free_len[i] == need) begin
          drop_slot(i);
        end else begin
          free_start[i] = free_start[i] + need[18:0];
          free_len[i] = free_len[i] - need;
        end
        return ffra_pkg::ST_OK;
      end
    end
    return ffra_pkg::ST_NO_FIT;
  endfunction

  // Ordered insert with merging; an equal start goes in front of the existing range
  function automatic logic [2:0] return_range(input logic [18:0] s, input logic [19:0] len);
    int pos;
    logic link_prev, link_next;
    longint unsigned merged;
    pos = 0;
    link_prev = 1'b0;
    link_next = 1'b0;
    while (pos < free_cnt && free_start[pos] < s) pos++;
    if (pos > 0)
      link_prev = (64'(free_start[pos-1]) + 64'(free_len[pos-1])) == 64'(s);
    if (pos < free_cnt)
      link_next = (64'(s) + 64'(len)) == 64'(free_start[pos]);
    if (link_prev) begin
      merged = 64'(free_len[pos-1]) + 64'(len);
      if (link_next) begin
        merged += 64'(free_len[pos]);
        drop_slot(pos);
      end
      free_len[pos-1] = clamp_len(merged);
      return ffra_pkg::ST_OK;
    end
    if (link_next) begin
      free_start[pos] = s;
      free_len[pos] = clamp_len(64'(free_len[pos]) + 64'(len));
      return ffra_pkg::ST_OK;
    end
    if (free_cnt >= FREE_SLOTS) return ffra_pkg::ST_LIST_FULL;
    for (int j = free_cnt; j > pos; j--) begin
      free_start[j] = free_start[j-1];
      free_len[j] = free_len[j-1];
    end
    free_start[pos] = s;
    free_len[pos] = len;
    free_cnt++;
    return ffra_pkg::ST_OK;
  endfunction

  function automatic reply_t predict_reply(input logic kind, input logic [19:0] count,
                                           input logic [18:0] start);
    reply_t r;
    logic [18:0] g;
    g = '0;
    r.kind = kind;
    r.count = count;
    r.start = start;
    if (!cfg_enable) r.status = ffra_pkg::ST_DISABLED;
    else if (kind == ffra_pkg::KIND_ALLOC) r.status = carve_first_fit(count, g);
    else if (count == 0) r.status = ffra_pkg::ST_ZERO_LEN;
    else r.status = return_range(start, count);
    r.granted = (r.status == ffra_pkg::ST_OK) ? g : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Timing helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int sender_gap();
    int r;
    if (!idle_mix) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int stall_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(12, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer one transaction, predict it when accepted, then maybe idle
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [19:0] count,
                           input logic [18:0] start);
    reply_t r;
    grant_t g;
    int gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_page_count <= count;
    in_start_page <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_reply(kind, count, start);
    pending_replies.insert(pending_replies.size(), r);
    items_sent++;
    if (kind == ffra_pkg::KIND_ALLOC && r.status == ffra_pkg::ST_OK && count != 0) begin
      g.start = r.granted;
      g.len = count;
      live_grants.insert(live_grants.size(), g);
    end
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input side until every outstanding result has been checked
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // APB write, only ever issued with the block idle
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    wait_for_replies();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ENABLE_ADDR) cfg_enable = value[0];
    else cfg_pages = value[19:0];
    rebuild_free_list();
    live_grants.delete();
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [19:0] alloc_size(input logic [19:0] arena);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 20'($urandom_range(1, 16));
    if (r < 85) return 20'($urandom_range(17, arena / 64));
    if (r < 95) return 20'($urandom_range(1, arena / 4));
    if (r < 97) return 20'd0;
    if (r < 99) return ffra_pkg::PAGE_CAP;
    return 20'($urandom_range(0, 524288));
  endfunction

  // Mostly well-formed: allocate, or give back something handed out earlier
  // (now and then only part of it); the rest is noise frees anywhere
  task automatic send_random_item(input logic [19:0] arena);
    int pick, idx;
    grant_t g;
    logic [19:0] cnt, off;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if ($urandom_range(0, 3) == 0) cnt = '0;
      else if ($urandom_range(0, 1) == 0) cnt = 20'($urandom_range(1, 64));
      else cnt = 20'($urandom_range(1, 524288));
      send_item(ffra_pkg::KIND_FREE, cnt, 19'($urandom));
    end else if (pick < 55 && live_grants.size() != 0) begin
      idx = $urandom_range(0, live_grants.size() - 1);
      g = live_grants[idx];
      live_grants.delete(idx);
      if (g.len > 1 && $urandom_range(0, 6) == 0) begin
        off = 20'($urandom_range(0, g.len - 1));
        cnt = 20'($urandom_range(1, g.len - off));
        send_item(ffra_pkg::KIND_FREE, cnt, g.start + off[18:0]);
      end else begin
        send_item(ffra_pkg::KIND_FREE, g.len, g.start);
      end
    end else begin
      send_item(ffra_pkg::KIND_ALLOC, alloc_size(arena), 19'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset arena of 32768 pages: zero lengths, exact fit, merges, equal start
  task automatic test_alloc_free_basics();
    send_item(ffra_pkg::KIND_ALLOC, 20'd0, 19'($urandom)); // zero-length alloc, list kept
    send_item(ffra_pkg::KIND_ALLOC, 20'd1, 19'h7FFFF);      // shrink from the front
    send_item(ffra_pkg::KIND_FREE, 20'd0, 19'd0);           // zero-length free ignored
    send_item(ffra_pkg::KIND_FREE, 20'd1, 19'd0);           // join with the next range
    send_item(ffra_pkg::KIND_ALLOC, 20'd32768, 19'd0);      // exact fit empties the list
    send_item(ffra_pkg::KIND_ALLOC, 20'd0, 19'd0);          // zero length on an empty list
    send_item(ffra_pkg::KIND_ALLOC, 20'd1, 19'd0);
    send_item(ffra_pkg::KIND_FREE, 20'd50, 19'd100);        // insert into an empty list
    send_item(ffra_pkg::KIND_FREE, 20'd10, 19'd100);        // equal start goes in front
    send_item(ffra_pkg::KIND_FREE, 20'd5, 19'd150);         // join with the previous range
    send_item(ffra_pkg::KIND_FREE, 20'd10, 19'd90);
    send_item(ffra_pkg::KIND_ALLOC, ffra_pkg::PAGE_CAP, 19'd0); // nothing that large
    send_item(ffra_pkg::KIND_ALLOC, 20'd55, 19'd0);         // skip a short range, exact fit
    send_item(ffra_pkg::KIND_ALLOC, 20'd20, 19'd0);
  endtask

  // Largest, oversized, empty and smallest arenas; longest range; start wrap
  task automatic test_arena_extremes();
    write_register(PAGES_ADDR, 32'(ffra_pkg::PAGE_CAP));
    send_item(ffra_pkg::KIND_FREE, ffra_pkg::PAGE_CAP, 19'h7FFFF); // runs past the end of the arena
    send_item(ffra_pkg::KIND_ALLOC, ffra_pkg::PAGE_CAP, 19'd0);
    send_item(ffra_pkg::KIND_FREE, 20'd524287, 19'd0);      // merges to the longest range
    send_item(ffra_pkg::KIND_ALLOC, ffra_pkg::PAGE_CAP, 19'd0); // new start wraps to zero
    send_item(ffra_pkg::KIND_ALLOC, 20'd524287, 19'd0);
    write_register(PAGES_ADDR, 32'h000F_FFFF);              // capped to the largest arena
    send_item(ffra_pkg::KIND_ALLOC, ffra_pkg::PAGE_CAP, 19'd0);
    send_item(ffra_pkg::KIND_ALLOC, 20'd1, 19'd0);
    write_register(PAGES_ADDR, 32'd0);                      // empty list
    send_item(ffra_pkg::KIND_ALLOC, 20'd0, 19'd0);
    send_item(ffra_pkg::KIND_FREE, 20'd5, 19'd5);
    send_item(ffra_pkg::KIND_ALLOC, 20'd5, 19'd0);
    write_register(PAGES_ADDR, 32'd16384);
    send_item(ffra_pkg::KIND_ALLOC, 20'd16384, 19'd0);
    send_item(ffra_pkg::KIND_FREE, 20'd10, 19'h7FFFF);
    send_item(ffra_pkg::KIND_ALLOC, 20'd1, 19'd0);          // start wraps past the top
    send_item(ffra_pkg::KIND_ALLOC, 20'd9, 19'd0);
  endtask

  task automatic test_disabled_arena();
    write_register(ENABLE_ADDR, 32'd0);
    send_item(ffra_pkg::KIND_ALLOC, 20'd1, 19'd0);
    send_item(ffra_pkg::KIND_FREE, 20'd4, 19'd0);
    send_item(ffra_pkg::KIND_FREE, 20'd0, 19'd0);
    send_item(ffra_pkg::KIND_ALLOC, 20'd0, 19'h7FFFF);
    write_register(ENABLE_ADDR, 32'd1);                     // brings the arena back
    send_item(ffra_pkg::KIND_ALLOC, 20'd16, 19'd0);
  endtask

  // Fill every slot with isolated ranges in shuffled order, then overflow
  task automatic test_full_list();
    int order [FREE_SLOTS];
    logic [19:0] slot_len [FREE_SLOTS];
    int j, t, k;
    write_register(PAGES_ADDR, 32'd16384);
    send_item(ffra_pkg::KIND_ALLOC, 20'd16384, 19'd0);
    for (int i = 0; i < FREE_SLOTS; i++) begin
      order[i] = i;
      slot_len[i] = 20'($urandom_range(1, 3));
    end
    for (int i = FREE_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < FREE_SLOTS; i++)
      send_item(ffra_pkg::KIND_FREE, slot_len[order[i]], 19'(4 * order[i]));
    send_item(ffra_pkg::KIND_FREE, 20'd1, 19'd1000);        // needs a slot: dropped
    k = $urandom_range(1, FREE_SLOTS - 2);
    send_item(ffra_pkg::KIND_FREE, 20'd4 - slot_len[k], 19'(4 * k) + slot_len[k][18:0]);
    send_item(ffra_pkg::KIND_FREE, 20'd5, 19'd2000);        // takes the freed slot
    send_item(ffra_pkg::KIND_FREE, 20'd1, 19'd3000);        // full again
    send_item(ffra_pkg::KIND_FREE, 20'd5, 19'd1995);        // merges ahead: still accepted
    send_item(ffra_pkg::KIND_FREE, 20'd3, 19'd2005);        // merges behind
    send_item(ffra_pkg::KIND_ALLOC, slot_len[0], 19'd0);    // exact fit in slot 0
    repeat (4) send_item(ffra_pkg::KIND_ALLOC, 20'($urandom_range(1, 4)), 19'($urandom));
  endtask

  // Hold the result side off long enough that the input stalls behind it
  task automatic test_result_backpressure();
    write_register(PAGES_ADDR, 32'(ffra_pkg::PAGES_RESET));
    idle_mix = 1'b0;
    sink_hold_cycles = 400;
    repeat (20) send_random_item(ffra_pkg::PAGES_RESET);
    wait_for_replies();
    idle_mix = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (12) send_random_item(cfg_pages);
    wait_for_replies();
    repeat (12) send_random_item(cfg_pages);
  endtask

  task automatic test_random_phases();
    logic [19:0] arena [6];
    arena = '{ffra_pkg::PAGES_RESET, ffra_pkg::PAGE_CAP, 20'd16384,
              20'($urandom_range(16384, 524288)), 20'($urandom_range(16384, 65536)),
              20'($urandom_range(16384, 524288))};
    for (int p = 0; p < 6; p++) begin
      idle_mix = (p % 2 == 0);
      write_register(PAGES_ADDR, 32'(arena[p]));
      if (p == 3) begin
        write_register(ENABLE_ADDR, 32'd0);
        repeat (15) send_random_item(arena[p]);
        write_register(ENABLE_ADDR, 32'd1);
      end
      repeat (150) send_random_item(arena[p]);
    end
    idle_mix = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, with a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    forever begin
      @(posedge clk);
      hold = 0;
      if (sink_hold_cycles > 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else if (idle_mix && $urandom_range(0, 3) == 0) begin
        hold = stall_length();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted result with the oldest expectation, field by field
  always @(posedge clk) begin : reply_checker
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      replies_checked++;
      if (out_status < 5) status_seen[out_status]++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d page %0d",
                                  out_status, out_granted_page));
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d (kind %0d count %0d start %0d)",
                                    out_status, want.status, want.kind, want.count,
                                    want.start));
        if (out_granted_page !== want.granted)
          report_mismatch($sformatf("granted %0d, expected %0d (kind %0d count %0d start %0d)",
                                    out_granted_page, want.granted, want.kind, want.count,
                                    want.start));
      end
    end
  end

  // Give up when neither channel has moved a transaction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    rebuild_free_list();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_alloc_free_basics();
    test_arena_extremes();
    test_disabled_arena();
    test_full_list();
    test_result_backpressure();
    test_sender_pause();
    test_random_phases();

    // Drain, then let the block settle for its worst latency
    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions and %0d results across %0d register writes",
             items_sent, replies_checked, cfg_writes);
    $display("Status mix: ok %0d, no_fit %0d, list_full %0d, disabled %0d, zero-length %0d",
             status_seen[ffra_pkg::ST_OK], status_seen[ffra_pkg::ST_NO_FIT],
             status_seen[ffra_pkg::ST_LIST_FULL], status_seen[ffra_pkg::ST_DISABLED],
             status_seen[ffra_pkg::ST_ZERO_LEN]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
